/* rtl/mie_pkg.sv */
package mie_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned MOD_W  = DATA_W - 1;
  localparam int unsigned CNT_W  = $clog2(DATA_W + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic        [MOD_W-1:0]  modulus;
  } in_item_t;

  typedef struct packed {
    logic                     has_inverse;
    logic        [MOD_W-1:0]  divisor;
    logic        [MOD_W-1:0]  inverse;
    logic signed [DATA_W-1:0] coeff_x;
    logic signed [DATA_W-1:0] coeff_y;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_W,
    ST_EUC_CHK,
    ST_EUC_W,
    ST_INV_W,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    DIV_RED,
    DIV_EUC,
    DIV_INV
  } div_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    div_sel_t div_sel;
    logic     red_fix;
    logic     euc_upd;
    logic     inv_fix;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic r_zero;
    logic gcd_one;
    logic div_done;
  } ctrl_sts_t;

endpackage

/* rtl/mie_div.sv */
module mie_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mie_pkg::DATA_W-1:0]  dividend,
  input  logic [mie_pkg::MOD_W-1:0]   divisor,
  input  logic [mie_pkg::DATA_W-1:0]  mult_x,
  input  logic [mie_pkg::DATA_W-1:0]  mult_y,
  output logic                        done,
  output logic [mie_pkg::MOD_W-1:0]   rem,
  output logic [mie_pkg::DATA_W-1:0]  prod_x,
  output logic [mie_pkg::DATA_W-1:0]  prod_y
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [mie_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [mie_pkg::DATA_W-1:0]  num_r, num_nxt;
  logic [mie_pkg::MOD_W-1:0]   den_r, den_nxt;
  logic [mie_pkg::DATA_W-1:0]  rem_r, rem_nxt;
  logic [mie_pkg::DATA_W-1:0]  px_r, px_nxt;
  logic [mie_pkg::DATA_W-1:0]  py_r, py_nxt;
  logic [mie_pkg::DATA_W-1:0]  mx_r, mx_nxt;
  logic [mie_pkg::DATA_W-1:0]  my_r, my_nxt;
  logic [mie_pkg::DATA_W-1:0]  rem_sh;
  logic [mie_pkg::DATA_W-1:0]  den_ext;
  logic                        q_bit;

  // Restoring division, one quotient bit a cycle; each quotient bit also
  // feeds a shift-and-add product of the quotient with two coefficients.
  assign rem_sh  = {rem_r[mie_pkg::DATA_W-2:0], num_r[mie_pkg::DATA_W-1]};
  assign den_ext = {1'b0, den_r};
  assign q_bit   = (rem_sh >= den_ext);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    px_nxt   = px_r;
    py_nxt   = py_r;
    mx_nxt   = mx_r;
    my_nxt   = my_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mie_pkg::CNT_W'(mie_pkg::DATA_W);
      num_nxt  = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
      px_nxt   = '0;
      py_nxt   = '0;
      mx_nxt   = mult_x;
      my_nxt   = mult_y;
    end else if (busy_r) begin
      num_nxt = {num_r[mie_pkg::DATA_W-2:0], 1'b0};
      rem_nxt = q_bit ? (rem_sh - den_ext) : rem_sh;
      px_nxt  = {px_r[mie_pkg::DATA_W-2:0], 1'b0} + (q_bit ? mx_r : '0);
      py_nxt  = {py_r[mie_pkg::DATA_W-2:0], 1'b0} + (q_bit ? my_r : '0);
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == mie_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
  end

  assign done   = done_r;
  assign rem    = rem_r[mie_pkg::MOD_W-1:0];
  assign prod_x = px_r;
  assign prod_y = py_r;

endmodule

/* rtl/mie_dp.sv */
module mie_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mie_pkg::in_item_t   in_data,
  input  mie_pkg::ctrl_cmd_t  cmd,
  output mie_pkg::ctrl_sts_t  sts,
  output mie_pkg::out_item_t  out_data
);

  logic [mie_pkg::MOD_W-1:0]   m_r, m_nxt;
  logic [mie_pkg::DATA_W-1:0]  mag_r, mag_nxt;
  logic                        neg_r, neg_nxt;
  logic [mie_pkg::MOD_W-1:0]   lastr_r, lastr_nxt;
  logic [mie_pkg::MOD_W-1:0]   r_r, r_nxt;
  logic [mie_pkg::DATA_W-1:0]  x_r, x_nxt;
  logic [mie_pkg::DATA_W-1:0]  y_r, y_nxt;
  logic [mie_pkg::DATA_W-1:0]  lastx_r, lastx_nxt;
  logic [mie_pkg::DATA_W-1:0]  lasty_r, lasty_nxt;
  logic [mie_pkg::MOD_W-1:0]   inv_r, inv_nxt;
  mie_pkg::out_item_t          out_r, out_nxt;

  logic [mie_pkg::DATA_W-1:0]  in_val;
  logic [mie_pkg::DATA_W-1:0]  lastx_mag;
  logic [mie_pkg::DATA_W-1:0]  div_num;
  logic [mie_pkg::MOD_W-1:0]   div_den;
  logic                        div_done;
  logic [mie_pkg::MOD_W-1:0]   div_rem;
  logic [mie_pkg::DATA_W-1:0]  prod_x;
  logic [mie_pkg::DATA_W-1:0]  prod_y;

  assign in_val    = in_data.value;
  assign lastx_mag = lastx_r[mie_pkg::DATA_W-1] ? (~lastx_r + 1'b1) : lastx_r;

  always_comb begin
    case (cmd.div_sel)
      mie_pkg::DIV_RED: begin
        div_num = mag_r;
        div_den = m_r;
      end
      mie_pkg::DIV_EUC: begin
        div_num = {1'b0, lastr_r};
        div_den = r_r;
      end
      mie_pkg::DIV_INV: begin
        div_num = lastx_mag;
        div_den = m_r;
      end
      default: begin
        div_num = mag_r;
        div_den = m_r;
      end
    endcase
  end

  mie_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .mult_x   (x_r),
    .mult_y   (y_r),
    .done     (div_done),
    .rem      (div_rem),
    .prod_x   (prod_x),
    .prod_y   (prod_y)
  );

  always_comb begin
    m_nxt     = m_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    lastr_nxt = lastr_r;
    r_nxt     = r_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    lastx_nxt = lastx_r;
    lasty_nxt = lasty_r;
    inv_nxt   = inv_r;
    out_nxt   = out_r;
    if (cmd.load_in) begin
      m_nxt   = in_data.modulus;
      neg_nxt = in_val[mie_pkg::DATA_W-1];
      mag_nxt = in_val[mie_pkg::DATA_W-1] ? (~in_val + 1'b1) : in_val;
      inv_nxt = '0;
    end
    if (cmd.red_fix) begin
      lastr_nxt = (neg_r && (div_rem != '0)) ? (m_r - div_rem) : div_rem;
      r_nxt     = m_r;
      lastx_nxt = mie_pkg::DATA_W'(1);
      lasty_nxt = '0;
      x_nxt     = '0;
      y_nxt     = mie_pkg::DATA_W'(1);
    end
    if (cmd.euc_upd) begin
      lastr_nxt = r_r;
      r_nxt     = div_rem;
      lastx_nxt = x_r;
      lasty_nxt = y_r;
      x_nxt     = lastx_r - prod_x;
      y_nxt     = lasty_r - prod_y;
    end
    if (cmd.inv_fix) begin
      if (lastx_r[mie_pkg::DATA_W-1]) begin
        inv_nxt = (div_rem == '0) ? '0 : (m_r - div_rem);
      end else begin
        inv_nxt = div_rem;
      end
    end
    if (cmd.out_load) begin
      if (m_r == '0) begin
        out_nxt = '0;
      end else begin
        out_nxt.has_inverse = (lastr_r == mie_pkg::MOD_W'(1));
        out_nxt.divisor     = lastr_r;
        out_nxt.inverse     = inv_r;
        out_nxt.coeff_x     = lastx_r;
        out_nxt.coeff_y     = lasty_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    lastr_r <= lastr_nxt;
    r_r     <= r_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    lastx_r <= lastx_nxt;
    lasty_r <= lasty_nxt;
    inv_r   <= inv_nxt;
    out_r   <= out_nxt;
  end

  assign sts.m_zero   = (m_r == '0);
  assign sts.r_zero   = (r_r == '0);
  assign sts.gcd_one  = (lastr_r == mie_pkg::MOD_W'(1));
  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule

/* rtl/mie_ctrl.sv */
module mie_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mie_pkg::ctrl_sts_t  sts,
  output mie_pkg::ctrl_cmd_t  cmd
);

  mie_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            can_load;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mie_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = mie_pkg::ST_RED_GO;
        end
      end
      mie_pkg::ST_RED_GO: begin
        state_nxt = sts.m_zero ? mie_pkg::ST_FIN : mie_pkg::ST_RED_W;
      end
      mie_pkg::ST_RED_W: begin
        if (sts.div_done) begin
          state_nxt = mie_pkg::ST_EUC_CHK;
        end
      end
      mie_pkg::ST_EUC_CHK: begin
        if (!sts.r_zero) begin
          state_nxt = mie_pkg::ST_EUC_W;
        end else if (sts.gcd_one) begin
          state_nxt = mie_pkg::ST_INV_W;
        end else begin
          state_nxt = mie_pkg::ST_FIN;
        end
      end
      mie_pkg::ST_EUC_W: begin
        if (sts.div_done) begin
          state_nxt = mie_pkg::ST_EUC_CHK;
        end
      end
      mie_pkg::ST_INV_W: begin
        if (sts.div_done) begin
          state_nxt = mie_pkg::ST_FIN;
        end
      end
      mie_pkg::ST_FIN: begin
        if (can_load) begin
          state_nxt = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mie_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load_in   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = mie_pkg::DIV_RED;
    cmd.red_fix   = 1'b0;
    cmd.euc_upd   = 1'b0;
    cmd.inv_fix   = 1'b0;
    cmd.out_load  = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      mie_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      mie_pkg::ST_RED_GO: begin
        cmd.div_start = !sts.m_zero;
        cmd.div_sel   = mie_pkg::DIV_RED;
      end
      mie_pkg::ST_RED_W: begin
        cmd.red_fix = sts.div_done;
      end
      mie_pkg::ST_EUC_CHK: begin
        if (!sts.r_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mie_pkg::DIV_EUC;
        end else if (sts.gcd_one) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = mie_pkg::DIV_INV;
        end
      end
      mie_pkg::ST_EUC_W: begin
        cmd.euc_upd = sts.div_done;
        cmd.div_sel = mie_pkg::DIV_EUC;
      end
      mie_pkg::ST_INV_W: begin
        cmd.inv_fix = sts.div_done;
        cmd.div_sel = mie_pkg::DIV_INV;
      end
      mie_pkg::ST_FIN: begin
        cmd.out_load = can_load;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mie_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/modular_inverse_ext_euclid_unit.sv */
// An item with a nonzero modulus runs a reduction division, then one division per Euclid step, and,
// when it has an inverse, a final division that reduces the coefficient into the modulus range.
// Each division makes 32 bit-serial steps; its done flag is registered, then the controller acts on it.
// A result is loaded only once the pending one is taken by out_ready, or when none is pending.
// One item is in work at a time; the next is taken from the cycle after the result is loaded.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out_valid.
module modular_inverse_ext_euclid_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mie_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mie_pkg::out_item_t  out_data
);

  mie_pkg::ctrl_cmd_t cmd;
  mie_pkg::ctrl_sts_t sts;

  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mie_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken before the previous one finished");

  a_div_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !sts.div_done)
    else $error("division finished one cycle after start");

  a_inverse_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.has_inverse) |-> (out_data.inverse == '0))
    else $error("inverse reported without a unit gcd");

endmodule
